// ===== sv/orcf_pkg.sv =====
// shared types and codes for the overlay rectangle change filter
package orcf_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [2:0] CMD_DET_DRAW  = 3'd0;
  localparam logic [2:0] CMD_TRK_DRAW  = 3'd1;
  localparam logic [2:0] CMD_CLR_SLOT  = 3'd2;
  localparam logic [2:0] CMD_CLR_ALL   = 3'd3;
  localparam logic [2:0] CMD_CLR_SCRN  = 3'd4;
  localparam logic [2:0] CMD_INVAL_ALL = 3'd5;

  localparam logic [2:0] KIND_DASHED   = 3'd0;
  localparam logic [2:0] KIND_SOLID    = 3'd1;
  localparam logic [2:0] KIND_CLR_SLOT = 3'd2;
  localparam logic [2:0] KIND_CLR_ALL  = 3'd3;
  localparam logic [2:0] KIND_CLR_SCRN = 3'd4;

  typedef struct packed {
    logic        has_clear;
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [3:0]  cls;
    logic [31:0] rect;
  } job_t;

endpackage

// ===== sv/orcf_front.sv =====
// front end: slot table, change detection and job generation
module orcf_front #(
  parameter int NUM_SLOTS = orcf_pkg::NUM_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_cmd,
  input  logic [7:0]       in_slot,
  input  logic [7:0]       in_rect_x,
  input  logic [7:0]       in_rect_y,
  input  logic [7:0]       in_rect_w,
  input  logic [7:0]       in_rect_h,
  input  logic [3:0]       in_obj_class,
  output logic             push,
  output orcf_pkg::job_t   push_job,
  input  logic             q_full
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [7:0] x_r [NUM_SLOTS];
  logic [7:0] y_r [NUM_SLOTS];
  logic [7:0] w_r [NUM_SLOTS];
  logic [7:0] h_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] solid_r;
  logic [NUM_SLOTS-1:0] valid_r;

  logic             accept;
  logic             slot_ok;
  logic             solid_req;
  logic [IDX_W-1:0] idx;
  logic             changed;
  logic             store;
  logic             clr_one;
  logic             zero_all;
  logic             inval_all;
  logic [31:0]      rect;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign slot_ok   = in_slot < 8'(NUM_SLOTS);
  assign solid_req = (in_cmd == orcf_pkg::CMD_TRK_DRAW);
  assign idx       = solid_req ? '0 : in_slot[IDX_W-1:0];
  assign rect      = {in_rect_h, in_rect_w, in_rect_y, in_rect_x};
  assign changed   = !valid_r[idx] || (x_r[idx] != in_rect_x) || (y_r[idx] != in_rect_y) ||
                     (w_r[idx] != in_rect_w) || (h_r[idx] != in_rect_h) ||
                     (solid_r[idx] != solid_req);

  always_comb begin
    push      = 1'b0;
    store     = 1'b0;
    clr_one   = 1'b0;
    zero_all  = 1'b0;
    inval_all = 1'b0;
    push_job  = '0;
    case (in_cmd)
      orcf_pkg::CMD_DET_DRAW: begin
        if (slot_ok && changed) begin
          push               = accept;
          store              = accept;
          push_job.has_clear = valid_r[idx];
          push_job.kind      = orcf_pkg::KIND_DASHED;
          push_job.slot      = in_slot[3:0];
          push_job.cls       = in_obj_class;
          push_job.rect      = rect;
        end
      end
      orcf_pkg::CMD_TRK_DRAW: begin
        if (changed) begin
          push          = accept;
          store         = accept;
          push_job.kind = orcf_pkg::KIND_SOLID;
          push_job.rect = rect;
        end
      end
      orcf_pkg::CMD_CLR_SLOT: begin
        if (slot_ok && valid_r[idx]) begin
          push          = accept;
          clr_one       = accept;
          push_job.kind = orcf_pkg::KIND_CLR_SLOT;
          push_job.slot = in_slot[3:0];
        end
      end
      orcf_pkg::CMD_CLR_ALL: begin
        push          = accept;
        zero_all      = accept;
        push_job.kind = orcf_pkg::KIND_CLR_ALL;
      end
      orcf_pkg::CMD_CLR_SCRN: begin
        push          = accept;
        zero_all      = accept;
        push_job.kind = orcf_pkg::KIND_CLR_SCRN;
      end
      orcf_pkg::CMD_INVAL_ALL: begin
        inval_all = accept;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solid_r <= '0;
      valid_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        x_r[i] <= '0;
        y_r[i] <= '0;
        w_r[i] <= '0;
        h_r[i] <= '0;
      end
    end else begin
      if (store) begin
        x_r[idx]     <= in_rect_x;
        y_r[idx]     <= in_rect_y;
        w_r[idx]     <= in_rect_w;
        h_r[idx]     <= in_rect_h;
        solid_r[idx] <= solid_req;
        valid_r[idx] <= 1'b1;
      end
      if (clr_one) begin
        valid_r[idx] <= 1'b0;
      end
      if (zero_all) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          x_r[i] <= '0;
          y_r[i] <= '0;
          w_r[i] <= '0;
          h_r[i] <= '0;
        end
      end
      if (inval_all) begin
        valid_r <= '0;
      end
    end
  end

endmodule

// ===== sv/orcf_queue.sv =====
// short job queue between front and back
module orcf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  orcf_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output orcf_pkg::job_t head_job
);

  localparam int DEPTH = orcf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  orcf_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/orcf_back.sv =====
// back end: expands jobs into result beats through an output register
module orcf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  orcf_pkg::job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_kind,
  output logic [3:0]     out_slot,
  output logic [3:0]     out_class,
  output logic [31:0]    out_packed_rect,
  output logic           out_last
);

  typedef enum logic {PH_FIRST, PH_MAIN} phase_t;

  phase_t      phase_r;
  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [3:0]  slot_r;
  logic [3:0]  class_r;
  logic [31:0] rect_r;
  logic        last_r;
  logic        load;
  logic        clear_beat;

  assign load       = !out_valid_r || out_ready;
  assign clear_beat = head_job.has_clear && (phase_r == PH_FIRST);
  assign pop        = load && head_valid && !clear_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        slot_r <= head_job.slot;
        if (clear_beat) begin
          phase_r <= PH_MAIN;
          kind_r  <= orcf_pkg::KIND_CLR_SLOT;
          class_r <= '0;
          rect_r  <= '0;
          last_r  <= 1'b0;
        end else begin
          phase_r <= PH_FIRST;
          kind_r  <= head_job.kind;
          class_r <= head_job.cls;
          rect_r  <= head_job.rect;
          last_r  <= 1'b1;
        end
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_slot        = slot_r;
  assign out_class       = class_r;
  assign out_packed_rect = rect_r;
  assign out_last        = last_r;

endmodule

// ===== sv/overlay_rect_change_filter_core.sv =====
// top level of the overlay rectangle change filter
// The front end takes one command per cycle while its two-entry job queue has
// room: it compares the command against the slot table, updates the table in
// that same cycle and queues a job for any command that produces results.
// The back end drains the queue into a registered output, one beat per cycle
// unless out_ready holds it back: tracker draws, dashed draws on empty slots
// and clears give one beat, a dashed draw that replaces a valid slot gives two
// (clear beat, then draw beat with out_last set). Commands that give no result
// queue no job. A command's job is written into the queue when it is accepted;
// its first result beat is then loaded into the output register.
// Reset empties the table, no clearing pass is needed.
module overlay_rect_change_filter_core #(
  parameter int NUM_SLOTS = orcf_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_slot,
  input  logic [7:0]  in_rect_x,
  input  logic [7:0]  in_rect_y,
  input  logic [7:0]  in_rect_w,
  input  logic [7:0]  in_rect_h,
  input  logic [3:0]  in_obj_class,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_slot,
  output logic [3:0]  out_class,
  output logic [31:0] out_packed_rect,
  output logic        out_last
);

  logic           push;
  orcf_pkg::job_t push_job;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  orcf_pkg::job_t head_job;

  orcf_front #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_slot     (in_slot),
    .in_rect_x   (in_rect_x),
    .in_rect_y   (in_rect_y),
    .in_rect_w   (in_rect_w),
    .in_rect_h   (in_rect_h),
    .in_obj_class(in_obj_class),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  orcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  orcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_slot       (out_slot),
    .out_class      (out_class),
    .out_packed_rect(out_packed_rect),
    .out_last       (out_last)
  );

endmodule
